[src/sat_pkg.sv]
`default_nettype none

package sat_pkg;

    // Fixed field widths of the item and result payloads.
    localparam int FUNC_W      = 3;
    localparam int FIELD_IDX_W = 5;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 3;
    localparam int CFG_W       = 5;

    localparam logic [CFG_W-1:0] SIZE_RESET = 5'd16;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT  = 3'd0,
        FN_EXCLUDE = 3'd1,
        FN_PUSH    = 3'd2,
        FN_UPDATE  = 3'd3,
        FN_ERASE   = 3'd4,
        FN_SWAP    = 3'd5,
        FN_REVERSE = 3'd6,
        FN_DUMP    = 3'd7
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_OCCUPIED = 3'd1,
        ST_INVALID  = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_FULL     = 3'd4,
        ST_NOT_SET  = 3'd5
    } stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_RD_A,
        S_RD_B,
        S_WR_A,
        S_WR_B,
        S_FIN,
        S_DUMP_RD,
        S_DUMP_EM
    } state_t;

    // Slot write source.
    typedef enum logic [2:0] {
        WR_NONE,
        WR_VAL_A,
        WR_VAL_PUSH,
        WR_CLR_A,
        WR_SWAP_A,
        WR_SWAP_B
    } wr_sel_t;

    // Pair/scan address setup.
    typedef enum logic [1:0] {
        AI_NONE,
        AI_SWAP,
        AI_REV,
        AI_ZERO
    } addr_init_t;

    typedef struct packed {
        logic       in_ready;
        logic       load_item;
        logic       rd_a;
        logic       rd_b;
        logic       cap_tmp;
        wr_sel_t    wr_sel;
        logic       erase;
        addr_init_t addr_init;
        logic       addr_step;
        logic       addr_inc;
        logic       emit;
        logic       emit_dump;
        stat_t      emit_status;
    } ctl_cmd_t;

    typedef struct packed {
        logic  in_valid;
        func_t func;
        logic  a_bad;
        logic  b_bad;
        logic  occ_a;
        logic  full;
        logic  n_lt2;
        logic  pair_more;
        logic  dump_last;
        logic  out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

[src/sat_item_if.sv]
`default_nettype none

interface sat_item_if import sat_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [FUNC_W-1:0]         func;
    logic [FIELD_IDX_W-1:0]    index_a;
    logic [FIELD_IDX_W-1:0]    index_b;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, func, index_a, index_b, value, input ready);
    modport sink   (input valid, func, index_a, index_b, value, output ready);
endinterface

`default_nettype wire

[src/sat_result_if.sv]
`default_nettype none

interface sat_result_if import sat_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] data;
    logic                      last;

    modport source (output valid, status, data, last, input ready);
    modport sink   (input valid, status, data, last, output ready);
endinterface

`default_nettype wire

[src/sat_ram.sv]
`default_nettype none

module sat_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[src/sat_ctrl.sv]
`default_nettype none

module sat_ctrl import sat_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire dp_stat_t st,
    output ctl_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (st.in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (st.func)
                    FN_SWAP:
                    begin
                        if (st.a_bad || st.b_bad)
                        begin
                            if (st.out_free)
                            begin
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            state_next = S_RD_A;
                        end
                    end
                    FN_REVERSE:
                    begin
                        if (st.n_lt2)
                        begin
                            if (st.out_free)
                            begin
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            state_next = S_RD_A;
                        end
                    end
                    FN_DUMP:
                    begin
                        state_next = S_DUMP_RD;
                    end
                    default:
                    begin
                        if (st.out_free)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_RD_A:
            begin
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                state_next = S_WR_A;
            end
            S_WR_A:
            begin
                state_next = S_WR_B;
            end
            S_WR_B:
            begin
                if (st.func == FN_REVERSE && st.pair_more)
                begin
                    state_next = S_RD_A;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DUMP_RD:
            begin
                state_next = S_DUMP_EM;
            end
            S_DUMP_EM:
            begin
                if (st.out_free)
                begin
                    state_next = st.dump_last ? S_IDLE : S_DUMP_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready  = 1'b1;
                cmd.load_item = st.in_valid;
            end
            S_EXEC:
            begin
                case (st.func)
                    FN_INSERT:
                    begin
                        if (st.out_free)
                        begin
                            cmd.emit = 1'b1;
                            if (st.a_bad)
                            begin
                                cmd.emit_status = ST_INVALID;
                            end
                            else if (st.occ_a)
                            begin
                                cmd.emit_status = ST_OCCUPIED;
                            end
                            else
                            begin
                                cmd.emit_status = ST_OK;
                                cmd.wr_sel      = WR_VAL_A;
                            end
                        end
                    end
                    FN_EXCLUDE:
                    begin
                        if (st.out_free)
                        begin
                            cmd.emit = 1'b1;
                            if (st.a_bad)
                            begin
                                cmd.emit_status = ST_INVALID;
                            end
                            else if (!st.occ_a)
                            begin
                                cmd.emit_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.emit_status = ST_OK;
                                cmd.wr_sel      = WR_CLR_A;
                            end
                        end
                    end
                    FN_PUSH:
                    begin
                        if (st.out_free)
                        begin
                            cmd.emit = 1'b1;
                            if (st.full)
                            begin
                                cmd.emit_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.emit_status = ST_OK;
                                cmd.wr_sel      = WR_VAL_PUSH;
                            end
                        end
                    end
                    FN_UPDATE:
                    begin
                        if (st.out_free)
                        begin
                            cmd.emit = 1'b1;
                            if (st.a_bad)
                            begin
                                cmd.emit_status = ST_INVALID;
                            end
                            else if (!st.occ_a)
                            begin
                                cmd.emit_status = ST_NOT_SET;
                            end
                            else
                            begin
                                cmd.emit_status = ST_OK;
                                cmd.wr_sel      = WR_VAL_A;
                            end
                        end
                    end
                    FN_ERASE:
                    begin
                        if (st.out_free)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = ST_OK;
                            cmd.erase       = 1'b1;
                        end
                    end
                    FN_SWAP:
                    begin
                        if (st.a_bad || st.b_bad)
                        begin
                            if (st.out_free)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = ST_INVALID;
                            end
                        end
                        else
                        begin
                            cmd.addr_init = AI_SWAP;
                        end
                    end
                    FN_REVERSE:
                    begin
                        if (st.n_lt2)
                        begin
                            if (st.out_free)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = ST_OK;
                            end
                        end
                        else
                        begin
                            cmd.addr_init = AI_REV;
                        end
                    end
                    FN_DUMP:
                    begin
                        cmd.addr_init = AI_ZERO;
                    end
                    default:
                    begin
                        cmd.addr_init = AI_NONE;
                    end
                endcase
            end
            S_RD_A:
            begin
                cmd.rd_a = 1'b1;
            end
            S_RD_B:
            begin
                cmd.rd_b    = 1'b1;
                cmd.cap_tmp = 1'b1;
            end
            S_WR_A:
            begin
                cmd.wr_sel = WR_SWAP_A;
            end
            S_WR_B:
            begin
                cmd.wr_sel    = WR_SWAP_B;
                cmd.addr_step = (st.func == FN_REVERSE) && st.pair_more;
            end
            S_FIN:
            begin
                if (st.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_OK;
                end
            end
            S_DUMP_RD:
            begin
                cmd.rd_a = 1'b1;
            end
            S_DUMP_EM:
            begin
                if (st.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_dump = 1'b1;
                    cmd.addr_inc  = !st.dump_last;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/sat_dpath.sv]
`default_nettype none

module sat_dpath import sat_pkg::*; #(
    parameter int SLOTS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_wr_data,
    sat_item_if.sink              item_ch,
    sat_result_if.source          result_ch,
    input  wire ctl_cmd_t         cmd,
    output dp_stat_t              st
);

    localparam int AW = $clog2(SLOTS);
    localparam int NW = $clog2(SLOTS + 1);
    localparam int CW = (NW > FIELD_IDX_W) ? NW : FIELD_IDX_W;

    logic [CFG_W-1:0]   active_size_reg;
    logic [CW-1:0]      as_ext;
    logic [NW-1:0]      n_eff;
    logic [NW-1:0]      n_m1;
    logic [SLOTS-1:0]   range_mask;

    func_t              func_reg;
    logic [CW-1:0]      ia_reg;
    logic [CW-1:0]      ib_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [AW-1:0]      ia_idx;

    logic [SLOTS-1:0]   occ_reg;
    logic [SLOTS-1:0]   free_vec;
    logic [SLOTS-1:0]   low_vec;
    logic [AW-1:0]      push_idx;

    logic [AW-1:0]      addr_a_reg;
    logic [AW-1:0]      addr_b_reg;
    logic [VALUE_W-1:0] tmp_val_reg;
    logic               tmp_occ_reg;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    logic               out_valid_reg;
    stat_t              out_status_reg;
    logic [VALUE_W-1:0] out_data_reg;
    logic               out_last_reg;
    logic               out_free;

    // size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_size_reg <= SIZE_RESET;
        end
        else if (cfg_wr_en)
        begin
            active_size_reg <= cfg_wr_data;
        end
    end

    // effective size: zero acts as one, clamp to SLOTS
    always_comb
    begin
        as_ext = CW'(active_size_reg);
        if (active_size_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (as_ext > CW'(SLOTS))
        begin
            n_eff = NW'(SLOTS);
        end
        else
        begin
            n_eff = as_ext[NW-1:0];
        end
        n_m1 = n_eff - NW'(1);
        for (int i = 0; i < SLOTS; i++)
        begin
            range_mask[i] = NW'(i) < n_eff;
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            func_reg <= func_t'(item_ch.func);
            ia_reg   <= CW'(item_ch.index_a);
            ib_reg   <= CW'(item_ch.index_b);
            val_reg  <= item_ch.value;
        end
    end

    assign ia_idx = ia_reg[AW-1:0];

    // first empty slot: isolate lowest set bit of the free vector
    always_comb
    begin
        free_vec = ~occ_reg & range_mask;
        low_vec  = free_vec & (~free_vec + SLOTS'(1));
        push_idx = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (low_vec[i])
            begin
                push_idx = push_idx | AW'(i);
            end
        end
    end

    // pair / scan addresses
    always_ff @(posedge clk)
    begin
        case (cmd.addr_init)
            AI_SWAP:
            begin
                addr_a_reg <= ia_reg[AW-1:0];
                addr_b_reg <= ib_reg[AW-1:0];
            end
            AI_REV:
            begin
                addr_a_reg <= '0;
                addr_b_reg <= n_m1[AW-1:0];
            end
            AI_ZERO:
            begin
                addr_a_reg <= '0;
            end
            default:
            begin
                if (cmd.addr_step)
                begin
                    addr_a_reg <= addr_a_reg + AW'(1);
                    addr_b_reg <= addr_b_reg - AW'(1);
                end
                else if (cmd.addr_inc)
                begin
                    addr_a_reg <= addr_a_reg + AW'(1);
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_tmp)
        begin
            tmp_val_reg <= ram_rdata;
            tmp_occ_reg <= occ_reg[addr_a_reg];
        end
    end

    // slot storage ports
    always_comb
    begin
        ram_re    = cmd.rd_a || cmd.rd_b;
        ram_raddr = cmd.rd_b ? addr_b_reg : addr_a_reg;
        ram_we    = 1'b0;
        ram_waddr = ia_idx;
        ram_wdata = val_reg;
        case (cmd.wr_sel)
            WR_VAL_A:
            begin
                ram_we = 1'b1;
            end
            WR_VAL_PUSH:
            begin
                ram_we    = 1'b1;
                ram_waddr = push_idx;
            end
            WR_SWAP_A:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_a_reg;
                ram_wdata = ram_rdata;
            end
            WR_SWAP_B:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_b_reg;
                ram_wdata = tmp_val_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    sat_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // occupancy flags; a clear flag reads as an empty slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            case (cmd.wr_sel)
                WR_VAL_A:
                begin
                    occ_reg[ia_idx] <= |val_reg;
                end
                WR_VAL_PUSH:
                begin
                    occ_reg[push_idx] <= |val_reg;
                end
                WR_CLR_A:
                begin
                    occ_reg[ia_idx] <= 1'b0;
                end
                WR_SWAP_A:
                begin
                    occ_reg[addr_a_reg] <= occ_reg[addr_b_reg];
                end
                WR_SWAP_B:
                begin
                    occ_reg[addr_b_reg] <= tmp_occ_reg;
                end
                default:
                begin
                    if (cmd.erase)
                    begin
                        occ_reg <= occ_reg & ~range_mask;
                    end
                end
            endcase
        end
    end

    // result register
    assign out_free = !out_valid_reg || result_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (cmd.emit_dump)
            begin
                out_status_reg <= ST_OK;
                out_data_reg   <= occ_reg[addr_a_reg] ? ram_rdata : '0;
                out_last_reg   <= st.dump_last;
            end
            else
            begin
                out_status_reg <= cmd.emit_status;
                out_data_reg   <= '0;
                out_last_reg   <= 1'b1;
            end
        end
    end

    assign item_ch.ready    = cmd.in_ready;
    assign result_ch.valid  = out_valid_reg;
    assign result_ch.status = out_status_reg;
    assign result_ch.data   = out_data_reg;
    assign result_ch.last   = out_last_reg;

    // status to controller
    always_comb
    begin
        st.in_valid  = item_ch.valid;
        st.func      = func_reg;
        st.a_bad     = ia_reg >= CW'(n_eff);
        st.b_bad     = ib_reg >= CW'(n_eff);
        st.occ_a     = occ_reg[ia_idx];
        st.full      = ~|free_vec;
        st.n_lt2     = n_eff < NW'(2);
        st.pair_more = ({1'b0, addr_a_reg} + (AW+1)'(2)) < {1'b0, addr_b_reg};
        st.dump_last = NW'(addr_a_reg) == n_m1;
        st.out_free  = out_free;
    end

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("result loaded while output register still held");

    a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ({1'b0, ram_waddr} < (AW+1)'(SLOTS)))
        else $error("slot write beyond table depth");

    a_erase_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.erase |=> ((occ_reg & $past(range_mask)) == '0))
        else $error("erase left an occupied slot in the active range");

endmodule

`default_nettype wire

[src/slot_array_table.sv]
// Insert, exclude, push, update, erase, bad swap, reverse of one slot: the execute state loads
//   the result once the output register is free; the next item is taken back in idle.
// Swap: read A, read B, write A, write B, then the result. Reverse: the same pair steps from
//   both ends inward over the effective size. Dump: read one slot, then emit it when the
//   output register is free, slot by slot. Pair ops are bound by the single RAM read port.
// Reset (rst_n low, async): controller idle, active size 16, all occupancy flags cleared
//   at once so every slot reads empty; no clearing pass, the item channel is ready at once.
`default_nettype none

module slot_array_table import sat_pkg::*; #(
    parameter int SLOTS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_wr_data,
    sat_item_if.sink              item_ch,
    sat_result_if.source          result_ch
);

    // Control path: the controller sequences each item through the datapath.
    // Single-slot ops are decided from the occupancy flags alone, so they write
    // and report from execute once the output is free. Swap and reverse share a
    // read-A / read-B / write-A / write-B pair sequence over one RAM read port;
    // reverse walks the pairs from both ends inward. Dump reads one slot, then
    // waits for the output register before presenting it with its last flag.
    ctl_cmd_t cmd;
    dp_stat_t st;

    sat_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    // Datapath: size register, item registers, occupancy flags (a cleared flag
    // reads as zero), slot RAM, pair address counters, and the output register
    // that lets the next item be accepted while a result waits downstream.
    sat_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_ch     (item_ch),
        .result_ch   (result_ch),
        .cmd         (cmd),
        .st          (st)
    );

endmodule

`default_nettype wire
